FILE: rtl/kdba_pkg.sv
// Shared definitions for the keyed directory bump allocator.
// Holds sizes, request and status codes, and the structs passed between modules.
// Depends on nothing.
package kdba_pkg;

  localparam int ENTRIES = 64;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int COUNT_W = $clog2(ENTRIES + 1);
  localparam int KEY_W   = 32;
  localparam int VAL_W   = 32;
  localparam int LIVE_W  = 7;

  localparam logic [1:0] REQ_PUT    = 2'd0;
  localparam logic [1:0] REQ_LOOKUP = 2'd1;
  localparam logic [1:0] REQ_FREE   = 2'd2;
  localparam logic [1:0] REQ_NONE   = 2'd3;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND = 3'd1;
  localparam logic [2:0] ST_NO_SLOT   = 3'd2;
  localparam logic [2:0] ST_OVER_CAP  = 3'd3;
  localparam logic [2:0] ST_TOO_LARGE = 3'd4;
  localparam logic [2:0] ST_INVALID   = 3'd5;

  typedef struct packed {
    logic             done;
    logic             match_found;
    logic [IDX_W-1:0] match_idx;
    logic             free_found;
    logic [IDX_W-1:0] free_idx;
  } scan_res_t;

  typedef struct packed {
    logic             en;
    logic             set;
    logic [IDX_W-1:0] idx;
    logic [KEY_W-1:0] key;
  } dir_wr_t;

endpackage

FILE: rtl/kdba_ram.sv
// Simple dual-port memory with one write port and one registered read port.
// Generic; used for the key store and for the slot offset and length store.
module kdba_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  logic                                        clk,
  input  logic                                        wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                            wr_data,
  input  logic                                        rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                            rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/kdba_scan.sv
// Directory scanner: key memory, slot valid bits and the one key comparator.
// Walks the slots in index order, one per cycle. Uses kdba_pkg and kdba_ram.
module kdba_scan import kdba_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             scan_start,
  input  logic [KEY_W-1:0] scan_key,
  input  dir_wr_t          dir_wr,
  output scan_res_t        res
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  logic [ENTRIES-1:0] valid;
  logic               issuing;
  logic [IDX_W-1:0]   issue_idx;
  logic               rd_valid;
  logic [IDX_W-1:0]   rd_idx;
  logic [KEY_W-1:0]   rd_key;

  kdba_ram #(.DEPTH(ENTRIES), .WIDTH(KEY_W)) u_key_ram (
    .clk     (clk),
    .wr_en   (dir_wr.en && dir_wr.set),
    .wr_addr (dir_wr.idx),
    .wr_data (dir_wr.key),
    .rd_en   (issuing),
    .rd_addr (issue_idx),
    .rd_data (rd_key)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      valid           <= '0;
      issuing         <= 1'b0;
      issue_idx       <= '0;
      rd_valid        <= 1'b0;
      res.done        <= 1'b0;
      res.match_found <= 1'b0;
      res.free_found  <= 1'b0;
    end else begin
      res.done <= 1'b0;
      rd_valid <= issuing && !scan_start;
      rd_idx   <= issue_idx;
      if (scan_start) begin
        issuing         <= 1'b1;
        issue_idx       <= '0;
        res.match_found <= 1'b0;
        res.free_found  <= 1'b0;
      end else begin
        if (issuing) begin
          if (issue_idx == LAST_IDX) begin
            issuing <= 1'b0;
          end else begin
            issue_idx <= IDX_W'(issue_idx + 1'b1);
          end
        end
        if (rd_valid) begin
          if (valid[rd_idx] && rd_key == scan_key && !res.match_found) begin
            res.match_found <= 1'b1;
            res.match_idx   <= rd_idx;
          end
          if (!valid[rd_idx] && !res.free_found) begin
            res.free_found <= 1'b1;
            res.free_idx   <= rd_idx;
          end
          if (rd_idx == LAST_IDX) begin
            res.done <= 1'b1;
          end
        end
      end
      if (dir_wr.en) begin
        valid[dir_wr.idx] <= dir_wr.set;
      end
    end
  end

endmodule

FILE: rtl/keyed_directory_bump_allocator.sv
// A request with a valid key is answered once the scan has walked every slot when the key is
// not in the directory, and after a further S_READ state for the slot memory read when it
// is; the scan reads the key memory one slot per cycle. An invalid request is answered in the
// next cycle. For a valid key, busy is high from acceptance until the cycle in which done
// pulses, and the next request may be taken in that cycle. Results stay on the result ports
// from done until the next result, and the receiver cannot stall them. The capacity register
// may be written whenever the block is idle, and its write channel is ready exactly then.
// Top level: sequencer, arena counters and capacity check. Uses kdba_pkg, kdba_scan, kdba_ram.
module keyed_directory_bump_allocator import kdba_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        req_type,
  input  logic [KEY_W-1:0]  key,
  input  logic [VAL_W-1:0]  byte_size,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [VAL_W-1:0]  cfg_data,
  output logic              done,
  output logic [2:0]        status,
  output logic              hit,
  output logic [VAL_W-1:0]  region_offset,
  output logic [VAL_W-1:0]  region_length,
  output logic [LIVE_W-1:0] live_entries,
  output logic [VAL_W-1:0]  arena_used
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_READ = 2'd2;

  localparam logic [VAL_W-1:0] CAP_RESET = VAL_W'(65536);

  logic [1:0]           state;
  logic [1:0]           r_type;
  logic [KEY_W-1:0]     r_key;
  logic [VAL_W-1:0]     r_size;
  logic [VAL_W-1:0]     capacity;
  logic [VAL_W-1:0]     used;
  logic [COUNT_W-1:0]   occupied;
  scan_res_t            scan;
  dir_wr_t              dir_wr;
  logic                 scan_start;
  logic                 accept;
  logic                 req_bad;
  logic                 over_cap;
  logic                 ram_wr_en;
  logic [IDX_W-1:0]     ram_wr_addr;
  logic [2*VAL_W-1:0]   ram_wr_data;
  logic [2*VAL_W-1:0]   ram_rd_data;
  logic [VAL_W-1:0]     cur_off;
  logic [VAL_W-1:0]     cur_len;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = !busy;
  assign accept    = start && !busy;
  assign req_bad   = (key == '0) || (req_type == REQ_NONE) ||
                     (req_type == REQ_PUT && byte_size == '0);
  assign scan_start = accept && !req_bad;
  assign over_cap  = ({1'b0, used} + {1'b0, r_size}) > {1'b0, capacity};
  assign cur_off   = ram_rd_data[2*VAL_W-1:VAL_W];
  assign cur_len   = ram_rd_data[VAL_W-1:0];
  assign live_entries = LIVE_W'(occupied);
  assign arena_used   = used;

  kdba_scan u_scan (
    .clk        (clk),
    .rst        (rst),
    .scan_start (scan_start),
    .scan_key   (r_key),
    .dir_wr     (dir_wr),
    .res        (scan)
  );

  kdba_ram #(.DEPTH(ENTRIES), .WIDTH(2 * VAL_W)) u_slot_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (state == S_SCAN && scan.done),
    .rd_addr (scan.match_idx),
    .rd_data (ram_rd_data)
  );

  always_comb begin
    dir_wr      = '0;
    ram_wr_en   = 1'b0;
    ram_wr_addr = scan.match_idx;
    ram_wr_data = {cur_off, r_size};
    if (state == S_SCAN && scan.done && !scan.match_found && r_type == REQ_PUT &&
        scan.free_found && !over_cap) begin
      dir_wr.en   = 1'b1;
      dir_wr.set  = 1'b1;
      dir_wr.idx  = scan.free_idx;
      dir_wr.key  = r_key;
      ram_wr_en   = 1'b1;
      ram_wr_addr = scan.free_idx;
      ram_wr_data = {used, r_size};
    end else if (state == S_READ) begin
      if (r_type == REQ_PUT && !(cur_len < r_size)) begin
        ram_wr_en = 1'b1;
      end
      if (r_type == REQ_FREE) begin
        dir_wr.en  = 1'b1;
        dir_wr.set = 1'b0;
        dir_wr.idx = scan.match_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      done     <= 1'b0;
      capacity <= CAP_RESET;
      used     <= '0;
      occupied <= '0;
    end else begin
      done <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        capacity <= cfg_data;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            r_type <= req_type;
            r_key  <= key;
            r_size <= byte_size;
            if (req_bad) begin
              done          <= 1'b1;
              status        <= ST_INVALID;
              hit           <= 1'b0;
              region_offset <= '0;
              region_length <= '0;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (scan.done) begin
            if (scan.match_found) begin
              state <= S_READ;
            end else begin
              state         <= S_IDLE;
              done          <= 1'b1;
              hit           <= 1'b0;
              region_offset <= '0;
              region_length <= '0;
              if (r_type != REQ_PUT) begin
                status <= ST_NOT_FOUND;
              end else if (!scan.free_found) begin
                status <= ST_NO_SLOT;
              end else if (over_cap) begin
                status <= ST_OVER_CAP;
              end else begin
                status        <= ST_OK;
                region_offset <= used;
                region_length <= r_size;
                used          <= VAL_W'(used + r_size);
                occupied      <= COUNT_W'(occupied + 1'b1);
              end
            end
          end
        end
        S_READ: begin
          state  <= S_IDLE;
          done   <= 1'b1;
          hit    <= 1'b1;
          status <= ST_OK;
          region_offset <= cur_off;
          region_length <= cur_len;
          if (r_type == REQ_PUT) begin
            if (cur_len < r_size) begin
              status <= ST_TOO_LARGE;
            end else begin
              region_length <= r_size;
            end
          end else if (r_type == REQ_FREE) begin
            region_offset <= '0;
            region_length <= '0;
            if (occupied != '0) begin
              occupied <= COUNT_W'(occupied - 1'b1);
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    occupied <= COUNT_W'(ENTRIES))
    else $error("occupied slot count exceeds the directory size");

  a_used_monotonic: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> used >= $past(used))
    else $error("arena top moved backwards");

  a_hit_status: assert property (@(posedge clk) disable iff (rst)
    done && hit |-> status == ST_OK || status == ST_TOO_LARGE)
    else $error("hit reported with a miss status");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    done && !hit && status != ST_OK |-> region_offset == '0 && region_length == '0)
    else $error("failed request reports a region");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result given while a request is still in progress");

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for keyed_directory_bump_allocator: directed and random requests,
// predicted by an in-bench directory and arena model. Depends on kdba_pkg and the RTL only.
module tb_top;
  import kdba_pkg::*;

  localparam int POOL_SIZE = 80;

  typedef struct packed {
    logic [2:0]        status;
    logic              hit;
    logic [VAL_W-1:0]  rofs;
    logic [VAL_W-1:0]  rlen;
    logic [LIVE_W-1:0] live;
    logic [VAL_W-1:0]  used;
  } alloc_result_t;

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  logic [1:0]        req_type;
  logic [KEY_W-1:0]  key;
  logic [VAL_W-1:0]  byte_size;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [VAL_W-1:0]  cfg_data;
  logic              done;
  logic [2:0]        status;
  logic              hit;
  logic [VAL_W-1:0]  region_offset;
  logic [VAL_W-1:0]  region_length;
  logic [LIVE_W-1:0] live_entries;
  logic [VAL_W-1:0]  arena_used;

  logic [KEY_W-1:0]  dir_key [ENTRIES];
  logic [VAL_W-1:0]  dir_offset [ENTRIES];
  logic [VAL_W-1:0]  dir_length [ENTRIES];
  logic [VAL_W-1:0]  arena_top;
  logic [LIVE_W-1:0] live_count;
  logic [VAL_W-1:0]  capacity_reg;
  logic [KEY_W-1:0]  key_pool [POOL_SIZE];

  alloc_result_t     expected_results [$];
  int unsigned       mismatch_count;
  bit                back_to_back;

  keyed_directory_bump_allocator dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .req_type      (req_type),
    .key           (key),
    .byte_size     (byte_size),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .done          (done),
    .status        (status),
    .hit           (hit),
    .region_offset (region_offset),
    .region_length (region_length),
    .live_entries  (live_entries),
    .arena_used    (arena_used)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("keyed_directory_bump_allocator regression: fail");
    $finish;
  end

  function automatic int find_key(input logic [KEY_W-1:0] k);
    for (int i = 0; i < ENTRIES; i++) begin
      if (dir_key[i] != '0 && dir_key[i] == k) begin
        return i;
      end
    end
    return -1;
  endfunction

  function automatic int first_free_slot();
    for (int i = 0; i < ENTRIES; i++) begin
      if (dir_key[i] == '0) begin
        return i;
      end
    end
    return -1;
  endfunction

  function automatic alloc_result_t predict_allocation(input logic [1:0] rt,
                                                       input logic [KEY_W-1:0] k,
                                                       input logic [VAL_W-1:0] sz);
    alloc_result_t r;
    int s;
    r = '0;
    r.status = ST_OK;
    if (k == '0 || rt == REQ_NONE) begin
      r.status = ST_INVALID;
    end else if (rt == REQ_PUT) begin
      s = find_key(k);
      if (sz == '0) begin
        r.status = ST_INVALID;
      end else if (s >= 0) begin
        r.hit = 1'b1;
        if (dir_length[s] < sz) begin
          r.status = ST_TOO_LARGE;
        end else begin
          dir_length[s] = sz;
        end
        r.rofs = dir_offset[s];
        r.rlen = dir_length[s];
      end else begin
        s = first_free_slot();
        if (s < 0) begin
          r.status = ST_NO_SLOT;
        end else if ({1'b0, arena_top} + {1'b0, sz} > {1'b0, capacity_reg}) begin
          r.status = ST_OVER_CAP;
        end else begin
          dir_key[s] = k;
          dir_offset[s] = arena_top;
          dir_length[s] = sz;
          r.rofs = arena_top;
          r.rlen = sz;
          arena_top = arena_top + sz;
          live_count = live_count + 1'b1;
        end
      end
    end else begin
      s = find_key(k);
      if (s < 0) begin
        r.status = ST_NOT_FOUND;
      end else if (rt == REQ_LOOKUP) begin
        r.hit = 1'b1;
        r.rofs = dir_offset[s];
        r.rlen = dir_length[s];
      end else begin
        r.hit = 1'b1;
        dir_key[s] = '0;
        dir_length[s] = '0;
        if (live_count > 0) begin
          live_count = live_count - 1'b1;
        end
      end
    end
    r.live = live_count;
    r.used = arena_top;
    return r;
  endfunction

  // Sizes lean towards small regions so that the arena lasts; three in ten of the puts to a
  // stored key ask for no more than its length, so that in-place rewrites succeed.
  function automatic logic [VAL_W-1:0] pick_size(input logic [KEY_W-1:0] k, input bit wide);
    int s;
    int unsigned p;
    s = find_key(k);
    p = $urandom_range(0, 99);
    if (s >= 0 && p < 30) begin
      return $urandom_range(1, dir_length[s]);
    end
    if (p < 36) begin
      return '0;
    end
    if (wide && p < 46) begin
      return $urandom;
    end
    if (p < 48) begin
      return 32'hFFFF_FFFF;
    end
    if (p < 58) begin
      return $urandom_range(257, 65536);
    end
    return $urandom_range(1, 256);
  endfunction

  task automatic send_request(input logic [1:0] rt, input logic [KEY_W-1:0] k,
                              input logic [VAL_W-1:0] sz);
    int unsigned gap;
    if ($urandom_range(0, 99) < 4) begin
      back_to_back = !back_to_back;
    end
    gap = back_to_back ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      start <= 1'b0;
      if ($urandom_range(0, 1) == 1) begin
        @(posedge clk);
        while (busy) @(posedge clk);
        gap--;
      end
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    req_type <= rt;
    key <= k;
    byte_size <= sz;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_results.push_back(predict_allocation(rt, k, sz));
  endtask

  task automatic wait_for_results(input int unsigned settle);
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [VAL_W-1:0] value);
    wait_for_results(2);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    capacity_reg = value;
  endtask

  // Runs at the reset capacity and ends with the arena filled to the last byte.
  task automatic test_directed_requests();
    send_request(REQ_LOOKUP, 32'h0000_1234, 32'd0);
    send_request(REQ_FREE, 32'h0000_1234, 32'd0);
    send_request(REQ_PUT, 32'h0, 32'd10);
    send_request(REQ_LOOKUP, 32'h0, 32'd0);
    send_request(REQ_FREE, 32'h0, 32'd0);
    send_request(REQ_NONE, 32'h5, 32'd7);
    send_request(REQ_NONE, 32'h0, 32'd0);
    send_request(REQ_PUT, 32'h0000_1234, 32'd0);
    send_request(REQ_PUT, 32'h0000_1234, 32'd100);
    send_request(REQ_PUT, 32'hFFFF_FFFF, 32'd1);
    send_request(REQ_LOOKUP, 32'h0000_1234, 32'hFFFF_FFFF);
    send_request(REQ_PUT, 32'h0000_1234, 32'd100);
    send_request(REQ_PUT, 32'h0000_1234, 32'd40);
    send_request(REQ_PUT, 32'h0000_1234, 32'd41);
    send_request(REQ_PUT, 32'h1, 32'hFFFF_FFFF);
    send_request(REQ_PUT, 32'h1, 32'd65436);
    send_request(REQ_PUT, 32'h1, 32'd65435);
    send_request(REQ_PUT, 32'h2, 32'd1);
    send_request(REQ_LOOKUP, 32'h1, 32'd0);
    send_request(REQ_FREE, 32'hFFFF_FFFF, 32'd0);
    send_request(REQ_LOOKUP, 32'hFFFF_FFFF, 32'd0);
    send_request(REQ_FREE, 32'hFFFF_FFFF, 32'd0);
    send_request(REQ_PUT, 32'hFFFF_FFFF, 32'd1);
  endtask

  // Fills every slot, shows that a full directory is reported before capacity, then frees the slots it filled.
  task automatic test_directory_full();
    int unsigned filled;
    write_capacity(32'hFFFF_FFFF);
    filled = 0;
    while (live_count < ENTRIES) begin
      send_request(REQ_PUT, 32'h8000_0000 + filled, $urandom_range(1, 16));
      filled++;
    end
    send_request(REQ_PUT, 32'h7FFF_0000, 32'hFFFF_FFFF);
    send_request(REQ_PUT, 32'h7FFF_0000, 32'd3);
    send_request(REQ_PUT, 32'h8000_0000, 32'd1);
    send_request(REQ_FREE, 32'h8000_0000 + filled / 2, 32'd0);
    send_request(REQ_PUT, 32'h7FFF_0000, 32'd3);
    send_request(REQ_LOOKUP, 32'h7FFF_0000, 32'd0);
    for (int i = 0; i < filled; i++) begin
      send_request(REQ_FREE, 32'h8000_0000 + i, $urandom);
    end
    send_request(REQ_FREE, 32'h7FFF_0000, 32'd0);
  endtask

  // Mostly well-formed puts, lookups and frees over a key set a little larger than the
  // directory, with some invalid keys and unused request types mixed in.
  task automatic test_random_traffic(input int unsigned count, input logic [VAL_W-1:0] cap,
                                     input bit wide);
    logic [1:0]       rt;
    logic [KEY_W-1:0] k;
    int unsigned      pick;
    write_capacity(cap);
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
      if (pick < 45) begin
        rt = REQ_PUT;
      end else if (pick < 70) begin
        rt = REQ_LOOKUP;
      end else if (pick < 92) begin
        rt = REQ_FREE;
      end else if (pick < 96) begin
        rt = REQ_NONE;
      end else begin
        rt = 2'($urandom_range(0, 2));
        k = '0;
      end
      send_request(rt, k, pick_size(k, wide));
    end
  endtask

  always @(posedge clk) begin
    alloc_result_t got;
    alloc_result_t want;
    if (!rst && done) begin
      got.status = status;
      got.hit = hit;
      got.rofs = region_offset;
      got.rlen = region_length;
      got.live = live_entries;
      got.used = arena_used;
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("%0t: result with no request outstanding: status %0d hit %0d", $time,
                   got.status, got.hit);
        end
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("%0t: expected status %0d hit %0d offset %h length %h live %0d used %h",
                     $time, want.status, want.hit, want.rofs, want.rlen, want.live, want.used);
            $display("%0t: actual   status %0d hit %0d offset %h length %h live %0d used %h",
                     $time, got.status, got.hit, got.rofs, got.rlen, got.live, got.used);
          end
        end
      end
    end
  end

  initial begin
    logic [VAL_W-1:0] mid_cap;
    rst <= 1'b1;
    start <= 1'b0;
    req_type <= REQ_PUT;
    key <= '0;
    byte_size <= '0;
    cfg_valid <= 1'b0;
    cfg_data <= '0;
    mismatch_count = 0;
    back_to_back = 1'b0;
    foreach (dir_key[i]) begin
      dir_key[i] = '0;
      dir_offset[i] = '0;
      dir_length[i] = '0;
    end
    arena_top = '0;
    live_count = '0;
    capacity_reg = 32'd65536;
    foreach (key_pool[i]) begin
      key_pool[i] = (i < 16) ? i + 1 : $urandom;
      if (key_pool[i] == '0) begin
        key_pool[i] = 32'hFFFF_FFFF;
      end
    end
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_directed_requests();
    test_directory_full();
    test_random_traffic(80, 32'd1, 1'b0);
    test_random_traffic(200, 32'h0010_0000, 1'b0);
    mid_cap = arena_top + $urandom_range(0, 32'h000F_FFFF);
    test_random_traffic(120, mid_cap, 1'b0);
    test_random_traffic(200, 32'hFFFF_FFFF, 1'b1);

    wait_for_results(80);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("keyed_directory_bump_allocator regression: pass");
    end else begin
      $display("keyed_directory_bump_allocator regression: fail");
    end
    $finish;
  end

endmodule
